// ===== hw/rtl/mpt_pkg.sv =====
// Shared types and constants for the Mandelbrot point test block.
`default_nettype none

package mpt_pkg;

  localparam int FRAC_BITS = 28;
  localparam int CW        = 32;                      // coordinate width
  localparam int PW        = 2 * CW;                  // product width
  localparam int NW        = PW + 2 - FRAC_BITS;      // width of an unsaturated new z part
  localparam int SW        = PW + 1;                  // width of the magnitude sum
  localparam int LIM_W     = 8;
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(100);
  localparam logic [SW-1:0]    ESC_BOUND = SW'(1) << (2 * FRAC_BITS + 2);  // 4.0 in product scale

  typedef struct packed {
    logic signed [CW-1:0] c_real;
    logic signed [CW-1:0] c_imag;
  } pt_in_t;

  typedef struct packed {
    logic             inside_res;
    logic [LIM_W-1:0] escape_count;
  } pt_res_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic sqr;
    logic step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic lim_zero;
    logic escaped;
    logic last;
  } dp_sts_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ADD  = 6'b000100,
    S_SQR  = 6'b001000,
    S_CHK  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mandelbrot_point_test_unit.sv =====
// Top level of the Mandelbrot escape-time point test.
//
// channel   signals                      beat taken when
// -------   --------------------------   ------------------------------
// config    cfg_we, cfg_wdata[7:0]       cfg_we high (max_iters)
// point     start, busy, point           start high and busy low
// result    done, result                 done high (one cycle, no stall)
//
// Each iteration steps through multiply, add, square and check (through one
// shared set of three 32x32 multipliers), after a load step; a final step
// presents the result. A point runs at most max_iters iterations; a limit
// of 0 goes from the load straight to the result.
// One point is in flight at a time; busy stays high from accept to result.
// Reset (rst, synchronous) returns the controller to idle and max_iters to 100.
// The receiver cannot stall: each result beat is on the ports for exactly one
// cycle, the cycle after which busy drops.
`default_nettype none

module mandelbrot_point_test_unit (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_we,
  input  wire  [mpt_pkg::LIM_W-1:0]      cfg_wdata,
  input  wire                            start,
  output logic                           busy,
  input  wire  mpt_pkg::pt_in_t          point,
  output logic                           done,
  output mpt_pkg::pt_res_t               result
);

  mpt_pkg::dp_cmd_t cmd;
  mpt_pkg::dp_sts_t sts;

  // sequencer
  mpt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // arithmetic and limit register
  mpt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .point     (point),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

  // an accepted point always makes the unit busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted point did not raise busy");

  // result beat lasts exactly one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held more than one cycle");

  // the unit is idle right after a result beat
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy still high after result beat");

  // busy only rises on an accepted point
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

endmodule

`default_nettype wire

// ===== hw/rtl/mpt_dp.sv =====
// Datapath: limit register, z registers, shared multipliers, escape test.
`default_nettype none

module mpt_dp (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [mpt_pkg::LIM_W-1:0]        cfg_wdata,
  input  wire  mpt_pkg::pt_in_t            point,
  input  wire  mpt_pkg::dp_cmd_t           cmd,
  output mpt_pkg::dp_sts_t                 sts,
  output mpt_pkg::pt_res_t                 result
);

  logic [mpt_pkg::LIM_W-1:0]          max_iters;
  logic signed [mpt_pkg::CW-1:0]      cr, ci, x, y;
  logic [mpt_pkg::LIM_W-1:0]          n;
  logic signed [mpt_pkg::PW-1:0]      pa, pb, pc;
  logic signed [mpt_pkg::NW-1:0]      nr, ni;
  logic                               ovf;

  logic signed [mpt_pkg::CW-1:0]      opa, opb;
  logic signed [mpt_pkg::PW:0]        diff, diff_sh;
  logic signed [mpt_pkg::PW-1:0]      xy_sh;
  logic signed [mpt_pkg::NW-1:0]      nr_next, ni_next;
  logic [mpt_pkg::SW-1:0]             mag_sum;

  function automatic logic fits_cw(input logic signed [mpt_pkg::NW-1:0] v);
    logic [mpt_pkg::NW-mpt_pkg::CW:0] top;
    top = v[mpt_pkg::NW-1:mpt_pkg::CW-1];
    return (top == '0) || (top == '1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iters <= mpt_pkg::LIM_RESET;
    end else if (cfg_we) begin
      max_iters <= cfg_wdata;
    end
  end

  // squares of z first, then squares of the candidate z for the magnitude test
  assign opa = cmd.sqr ? nr[mpt_pkg::CW-1:0] : x;
  assign opb = cmd.sqr ? ni[mpt_pkg::CW-1:0] : y;

  always_comb begin
    diff    = (mpt_pkg::PW+1)'(pa) - (mpt_pkg::PW+1)'(pb);
    diff_sh = diff >>> mpt_pkg::FRAC_BITS;
    xy_sh   = pc >>> (mpt_pkg::FRAC_BITS - 1);
    nr_next = mpt_pkg::NW'(diff_sh) + mpt_pkg::NW'(cr);
    ni_next = mpt_pkg::NW'(xy_sh) + mpt_pkg::NW'(ci);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr <= point.c_real;
      ci <= point.c_imag;
      x  <= point.c_real;
      y  <= point.c_imag;
      n  <= '0;
    end else if (cmd.step) begin
      // no escape: the candidate fits in CW bits, so saturation is a no-op
      x <= nr[mpt_pkg::CW-1:0];
      y <= ni[mpt_pkg::CW-1:0];
      n <= n + mpt_pkg::LIM_W'(1);
    end
    if (cmd.mul || cmd.sqr) begin
      pa <= opa * opa;
      pb <= opb * opb;
      pc <= opa * opb;
    end
    if (cmd.add) begin
      nr  <= nr_next;
      ni  <= ni_next;
      // a part beyond CW bits is beyond 8.0 and escapes for sure
      ovf <= !fits_cw(nr_next) || !fits_cw(ni_next);
    end
  end

  assign mag_sum = mpt_pkg::SW'(pa) + mpt_pkg::SW'(pb);

  assign sts.lim_zero = (max_iters == '0);
  assign sts.escaped  = ovf || (mag_sum > mpt_pkg::ESC_BOUND);
  assign sts.last     = ((n + mpt_pkg::LIM_W'(1)) == max_iters);

  assign result.escape_count = n;
  assign result.inside_res   =
    ((mpt_pkg::LIM_W+1)'(n) + (mpt_pkg::LIM_W+1)'(2)) >= (mpt_pkg::LIM_W+1)'(max_iters);

endmodule

`default_nettype wire

// ===== hw/rtl/mpt_ctrl.sv =====
// Controller: sequences load, multiply, add, square and check per iteration.
`default_nettype none

module mpt_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire  mpt_pkg::dp_sts_t   sts,
  output mpt_pkg::dp_cmd_t         cmd,
  output logic                     busy,
  output logic                     done
);

  mpt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      mpt_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = sts.lim_zero ? mpt_pkg::S_FIN : mpt_pkg::S_MUL;
        end
      end
      mpt_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = mpt_pkg::S_ADD;
      end
      mpt_pkg::S_ADD: begin
        cmd.add    = 1'b1;
        state_next = mpt_pkg::S_SQR;
      end
      mpt_pkg::S_SQR: begin
        cmd.sqr    = 1'b1;
        state_next = mpt_pkg::S_CHK;
      end
      mpt_pkg::S_CHK: begin
        if (sts.escaped) begin
          state_next = mpt_pkg::S_FIN;
        end else begin
          cmd.step   = 1'b1;
          state_next = sts.last ? mpt_pkg::S_FIN : mpt_pkg::S_MUL;
        end
      end
      mpt_pkg::S_FIN: begin
        state_next = mpt_pkg::S_IDLE;
      end
      default: begin
        state_next = mpt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != mpt_pkg::S_IDLE);
  assign done = (state == mpt_pkg::S_FIN);

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the Mandelbrot escape-time point test unit.
`default_nettype none

module tb;

  // Q4.28 unit, used to build directed points
  localparam int FX_ONE = 1 << mpt_pkg::FRAC_BITS;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_we    = 1'b0;
  logic [mpt_pkg::LIM_W-1:0] cfg_wdata = '0;
  logic                      start     = 1'b0;
  mpt_pkg::pt_in_t           point     = '0;
  logic                      busy;
  logic                      done;
  mpt_pkg::pt_res_t          result;

  // points waiting to be sent, results predicted for points already taken
  mpt_pkg::pt_in_t           pending_points[$];
  mpt_pkg::pt_res_t          expected_results[$];
  logic [mpt_pkg::LIM_W-1:0] lim_model = mpt_pkg::LIM_RESET;   // shadow of max_iters
  int                        err_count = 0;
  bit                        took      = 1'b0;   // point beat taken at the last rising edge
  int                        burst_left = 1;
  int                        gap_left   = 0;

  mandelbrot_point_test_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .point     (point),
    .done      (done),
    .result    (result)
  );

  always #5 clk = ~clk;

  // Escape-time prediction for one point at the given limit.
  // z starts at c; each step forms z*z + c in wide form, tests |z|^2 > 4 on the
  // unsaturated parts, and only a surviving step clamps z back to 32 bits.
  function automatic mpt_pkg::pt_res_t escape_eval(input mpt_pkg::pt_in_t p,
                                                   input logic [mpt_pkg::LIM_W-1:0] lim);
    longint              x, y, cr, ci, xx, yy, xy, nr, ni;
    logic signed [127:0] wr, wi, mag, bound;
    int                  n;
    mpt_pkg::pt_res_t    r;
    cr = p.c_real;
    ci = p.c_imag;
    x = cr;
    y = ci;
    n = 0;
    bound = 128'sd1 <<< (2 * mpt_pkg::FRAC_BITS + 2);
    while (n < int'(lim)) begin
      xx = x * x;
      yy = y * y;
      xy = x * y;
      // arithmetic shifts floor toward minus infinity
      nr = ((xx - yy) >>> mpt_pkg::FRAC_BITS) + cr;
      ni = (xy >>> (mpt_pkg::FRAC_BITS - 1)) + ci;
      wr = 128'(nr);
      wi = 128'(ni);
      mag = wr * wr + wi * wi;
      if (mag > bound) break;   // equal to 4 stays in
      x = (nr > 64'sd2147483647) ? 64'sd2147483647 :
          (nr < -64'sd2147483648) ? -64'sd2147483648 : nr;
      y = (ni > 64'sd2147483647) ? 64'sd2147483647 :
          (ni < -64'sd2147483648) ? -64'sd2147483648 : ni;
      n++;
    end
    // signed compare: limits 0 and 1 always report inside
    r.inside_res   = (n >= int'(lim) - 2);
    r.escape_count = n[mpt_pkg::LIM_W-1:0];
    return r;
  endfunction

  function automatic mpt_pkg::pt_in_t mk_point(input int re, input int im);
    mpt_pkg::pt_in_t p;
    p.c_real = re;
    p.c_imag = im;
    return p;
  endfunction

  // Random point: mostly the box around the set (real -2..0.5, imag -1.25..1.25)
  // where orbits run long, some near the tip and the cusp, some anywhere.
  function automatic mpt_pkg::pt_in_t rand_point();
    mpt_pkg::pt_in_t p;
    int unsigned     sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      p.c_real = $urandom_range(0, 671088640) - 536870912;
      p.c_imag = $urandom_range(0, 671088640) - 335544320;
    end else if (sel < 80) begin
      p.c_real = ((sel & 1) ? -2 * FX_ONE : FX_ONE / 4) + int'($urandom_range(0, 8191)) - 4096;
      p.c_imag = int'($urandom_range(0, 8191)) - 4096;
    end else begin
      p.c_real = $urandom;
      p.c_imag = $urandom;
    end
    return p;
  endfunction

  // Monitor: note point beats, predict at the edge that takes them, and check
  // every result beat against the oldest prediction.
  always @(posedge clk) begin
    took = !rst && start && !busy;
    if (took) expected_results.push_back(escape_eval(point, lim_model));
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got inside %0b count %0d",
                 $time, result.inside_res, result.escape_count);
        err_count++;
      end else begin
        if (result.inside_res !== expected_results[0].inside_res) begin
          $display("%0t: inside_res expected %0b got %0b", $time,
                   expected_results[0].inside_res, result.inside_res);
          err_count++;
        end
        if (result.escape_count !== expected_results[0].escape_count) begin
          $display("%0t: escape_count expected %0d got %0d", $time,
                   expected_results[0].escape_count, result.escape_count);
          err_count++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  // Driver: bursts of back-to-back points, then a random gap. While busy is
  // high the beat is simply held until taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_points.size() != 0) begin
        point <= pending_points.pop_front();
        start <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Wait until every point is sent and every result is back.
  task automatic drain_all();
    while (pending_points.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write max_iters while the unit is idle.
  task automatic set_limit(input logic [mpt_pkg::LIM_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    lim_model = v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int lims [8];
    lims = '{2, 255, 0, 1, 9, 0, 0, 100};
    lims[5] = $urandom_range(2, 255);
    lims[6] = $urandom_range(2, 255);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed points at the reset limit
    pending_points.push_back(mk_point(0, 0));
    pending_points.push_back(mk_point(32'h7FFFFFFF, 32'h7FFFFFFF));
    pending_points.push_back(mk_point(32'h80000000, 32'h80000000));
    pending_points.push_back(mk_point(32'h80000000, 0));
    pending_points.push_back(mk_point(0, 32'h80000000));
    pending_points.push_back(mk_point(32'h7FFFFFFF, 0));
    pending_points.push_back(mk_point(0, 32'h7FFFFFFF));
    pending_points.push_back(mk_point(32'h80000000, 32'h7FFFFFFF));
    pending_points.push_back(mk_point(32'h7FFFFFFF, 32'h80000000));
    // tip: orbit sits on |z| = 2 exactly, never escapes
    pending_points.push_back(mk_point(-2 * FX_ONE, 0));
    pending_points.push_back(mk_point(-2 * FX_ONE, 1));
    pending_points.push_back(mk_point(-2 * FX_ONE - 1, 0));
    pending_points.push_back(mk_point(2 * FX_ONE, 0));
    // cusp: very slow convergence
    pending_points.push_back(mk_point(FX_ONE / 4, 0));
    pending_points.push_back(mk_point(FX_ONE / 4 + 1, 0));
    pending_points.push_back(mk_point(0, FX_ONE));
    pending_points.push_back(mk_point(0, -FX_ONE));
    pending_points.push_back(mk_point(-FX_ONE, 0));
    pending_points.push_back(mk_point(-3 * FX_ONE / 4, FX_ONE / 10));
    pending_points.push_back(mk_point(FX_ONE / 2, FX_ONE / 2));
    pending_points.push_back(mk_point(-FX_ONE / 10, 9 * FX_ONE / 10));
    pending_points.push_back(mk_point(-FX_ONE, 3 * FX_ONE / 10));
    pending_points.push_back(mk_point(3 * FX_ONE / 10, -FX_ONE / 2));
    pending_points.push_back(mk_point(-1, -1));
    drain_all();

    // Random phases over several limits, the extremes included
    foreach (lims[i]) begin
      set_limit(mpt_pkg::LIM_W'(lims[i]));
      repeat (165) pending_points.push_back(rand_point());
      drain_all();
    end

    // room for any stray result beat after the last expected one
    repeat (4 * 255 + 20) @(posedge clk);
    if (err_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
